/* rtl/rtoe_pkg.sv */
// rtoe_pkg: shared types and constants for the rto estimator with backoff
// request codes, config register indexes, reset values, link state structs
// no dependencies
package rtoe_pkg;

    // request codes
    typedef enum logic [1:0] {
        REQ_RTT     = 2'd0,
        REQ_EXPIRY  = 2'd1,
        REQ_CONGEST = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_type_t;

    // config register indexes
    typedef enum logic [1:0] {
        CFG_TICKS     = 2'd0,
        CFG_LIMIT     = 2'd1,
        CFG_MSS       = 2'd2,
        CFG_THRESHOLD = 2'd3
    } cfg_index_t;

    // config reset values
    localparam logic [9:0]  RESET_TICKS     = 10'd1000;
    localparam logic [3:0]  RESET_LIMIT     = 4'd5;
    localparam logic [15:0] RESET_MSS       = 16'd1460;
    localparam logic [15:0] RESET_THRESHOLD = 16'hFFFF;

    // retry counter saturation value
    localparam logic [7:0]  RETRY_MAX       = 8'hFF;

    // timer and window state kept per connection
    typedef struct packed {
        logic [15:0] rto;
        logic [7:0]  retries;
        logic        failed;
        logic [16:0] cwnd;
        logic [16:0] ssthresh;
    } link_state_t;

    // result of the expiry and congestion path
    typedef struct packed {
        link_state_t nxt;
        logic        retransmit;
        logic [30:0] delay;
    } backoff_res_t;

endpackage

/* rtl/rtoe_rtt_calc.sv */
// rtoe_rtt_calc: srtt / rttvar update from one rtt sample and clamped rto
// combinational; uses rtoe_pkg
module rtoe_rtt_calc
    import rtoe_pkg::*;
#(
    parameter int SAMPLE_BITS = 20
) (
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] srtt,
    input  logic [SAMPLE_BITS-1:0] rttvar,
    input  logic [9:0]             ticks,
    output logic [SAMPLE_BITS-1:0] srtt_next,
    output logic [SAMPLE_BITS-1:0] rttvar_next,
    output logic [15:0]            rto_next
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int RW = SAMPLE_BITS + 3;

    logic signed [DW-1:0]    delta;
    logic [SAMPLE_BITS-1:0]  mag;
    logic signed [DW-1:0]    vdiff;
    logic [DW-1:0]           s_sum;
    logic [DW-1:0]           v_sum;
    logic [RW-1:0]           rto_sum;
    logic [15:0]             lo;
    logic [15:0]             hi;

    // signed error against the old estimate
    assign delta = signed'({1'b0, sample}) - signed'({1'b0, srtt});
    assign mag   = delta[DW-1] ? SAMPLE_BITS'(-delta) : delta[SAMPLE_BITS-1:0];
    assign vdiff = signed'({1'b0, mag}) - signed'({1'b0, rttvar});

    // gains of 1/8 and 1/4, floor division by arithmetic shift
    assign s_sum = {1'b0, srtt} + DW'(delta >>> 3);
    assign v_sum = {1'b0, rttvar} + DW'(vdiff >>> 2);

    // seed while the estimate is still zero
    always_comb begin
        if (srtt == '0) begin
            srtt_next   = sample;
            rttvar_next = sample >> 1;
        end else begin
            srtt_next   = s_sum[SAMPLE_BITS-1:0];
            rttvar_next = v_sum[SAMPLE_BITS-1:0];
        end
    end

    // rto = srtt + 4*rttvar, clamped to half a second .. sixty seconds
    assign rto_sum = {3'b000, srtt_next} + {1'b0, rttvar_next, 2'b00};
    assign lo      = {7'd0, ticks[9:1]};
    assign hi      = {6'd0, ticks} * 16'd60;

    always_comb begin
        if (rto_sum < RW'(lo)) begin
            rto_next = lo;
        end else if (rto_sum > RW'(hi)) begin
            rto_next = hi;
        end else begin
            rto_next = rto_sum[15:0];
        end
    end

endmodule

/* rtl/rtoe_backoff.sv */
// rtoe_backoff: timer expiry backoff and congestion window halving
// combinational; uses rtoe_pkg
module rtoe_backoff
    import rtoe_pkg::*;
(
    input  req_type_t    req,
    input  link_state_t  cur,
    input  logic [3:0]   retry_limit,
    input  logic [15:0]  segment_size,
    output backoff_res_t res
);

    logic        below_limit;
    logic [7:0]  retries_inc;
    logic [15:0] half_cwnd;
    logic [16:0] floor_win;
    logic [16:0] new_thresh;

    assign below_limit = cur.retries < {4'd0, retry_limit};
    assign retries_inc = (cur.retries == RETRY_MAX) ? cur.retries : cur.retries + 8'd1;

    // new threshold is the larger of half the window and two segments
    assign half_cwnd  = cur.cwnd[16:1];
    assign floor_win  = {segment_size, 1'b0};
    assign new_thresh = ({1'b0, half_cwnd} > floor_win) ? {1'b0, half_cwnd} : floor_win;

    always_comb begin
        res            = '0;
        res.nxt        = cur;
        case (req)
            REQ_EXPIRY: begin
                res.nxt.retries = retries_inc;
                if (below_limit) begin
                    res.retransmit = 1'b1;
                    res.delay      = 31'({15'd0, cur.rto} << retries_inc[3:0]);
                end else begin
                    res.nxt.failed = 1'b1;
                end
            end
            REQ_CONGEST: begin
                res.nxt.ssthresh = new_thresh;
                res.nxt.cwnd     = new_thresh;
            end
            default: begin
                res.nxt = cur;
            end
        endcase
    end

endmodule

/* rtl/rto_estimator_with_backoff.sv */
// rto_estimator_with_backoff: top level, request/result registers and state
// uses rtoe_pkg, rtoe_rtt_calc, rtoe_backoff
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  s_       | s_valid / s_ready  | s_req_type, s_rtt_sample
//  m_       | m_valid / m_ready  | srtt, rttvar, rto, delay, flags, windows
//  cfg_     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one request per cycle while the result channel does not stall; a result is
// shown after its request passes the request register, then the result register
// all estimator state updates in the cycle a request leaves its register
// aresetn (synchronous) loads the default config and the initial state
// a stalled result holds the request register; cfg_ready is always high
module rto_estimator_with_backoff
    import rtoe_pkg::*;
#(
    parameter int SAMPLE_BITS = 20
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // request channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_req_type,
    input  logic [SAMPLE_BITS-1:0] s_rtt_sample,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_BITS-1:0] m_smoothed_rtt,
    output logic [SAMPLE_BITS-1:0] m_rtt_variance,
    output logic [15:0]            m_timeout_value,
    output logic [30:0]            m_next_timer_delay,
    output logic                   m_retransmit_now,
    output logic                   m_connection_failed,
    output logic [16:0]            m_congestion_window,
    output logic [16:0]            m_slow_start_threshold,
    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data
);

    logic [9:0]             ticks_reg;
    logic [3:0]             limit_reg;
    logic [15:0]            mss_reg;
    logic [15:0]            thresh_reg;

    logic                   in_valid_reg;
    req_type_t              in_req_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;

    logic [SAMPLE_BITS-1:0] srtt_reg;
    logic [SAMPLE_BITS-1:0] rttvar_reg;
    link_state_t            link_reg;

    logic [SAMPLE_BITS-1:0] srtt_calc;
    logic [SAMPLE_BITS-1:0] rttvar_calc;
    logic [15:0]            rto_calc;
    backoff_res_t           bo_res;

    logic [SAMPLE_BITS-1:0] srtt_next;
    logic [SAMPLE_BITS-1:0] rttvar_next;
    link_state_t            link_next;

    logic                   out_valid_reg;
    logic                   advance;

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || !out_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg  <= RESET_TICKS;
            limit_reg  <= RESET_LIMIT;
            mss_reg    <= RESET_MSS;
            thresh_reg <= RESET_THRESHOLD;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TICKS:     ticks_reg  <= cfg_data[9:0];
                CFG_LIMIT:     limit_reg  <= cfg_data[3:0];
                CFG_MSS:       mss_reg    <= cfg_data;
                CFG_THRESHOLD: thresh_reg <= cfg_data;
                default:       ticks_reg  <= ticks_reg;
            endcase
        end
    end

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg    <= req_type_t'(s_req_type);
            in_sample_reg <= s_rtt_sample;
        end
    end

    // estimator datapath
    rtoe_rtt_calc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rtt_calc (
        .sample      (in_sample_reg),
        .srtt        (srtt_reg),
        .rttvar      (rttvar_reg),
        .ticks       (ticks_reg),
        .srtt_next   (srtt_calc),
        .rttvar_next (rttvar_calc),
        .rto_next    (rto_calc)
    );

    rtoe_backoff u_backoff (
        .req          (in_req_reg),
        .cur          (link_reg),
        .retry_limit  (limit_reg),
        .segment_size (mss_reg),
        .res          (bo_res)
    );

    // select the updated state by request type
    always_comb begin
        srtt_next   = srtt_reg;
        rttvar_next = rttvar_reg;
        link_next   = bo_res.nxt;
        if (in_req_reg == REQ_RTT) begin
            srtt_next     = srtt_calc;
            rttvar_next   = rttvar_calc;
            link_next.rto = rto_calc;
        end
    end

    // estimator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srtt_reg          <= '0;
            rttvar_reg        <= '0;
            link_reg.rto      <= {6'd0, RESET_TICKS};
            link_reg.retries  <= '0;
            link_reg.failed   <= 1'b0;
            link_reg.cwnd     <= {1'b0, RESET_MSS};
            link_reg.ssthresh <= {1'b0, RESET_THRESHOLD};
        end else if (advance) begin
            srtt_reg   <= srtt_next;
            rttvar_reg <= rttvar_next;
            link_reg   <= link_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_smoothed_rtt         <= srtt_next;
            m_rtt_variance         <= rttvar_next;
            m_timeout_value        <= link_next.rto;
            m_next_timer_delay     <= bo_res.delay;
            m_retransmit_now       <= bo_res.retransmit;
            m_connection_failed    <= link_next.failed;
            m_congestion_window    <= link_next.cwnd;
            m_slow_start_threshold <= link_next.ssthresh;
        end
    end

    // failure is sticky until reset
    a_failed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        link_reg.failed |=> link_reg.failed)
        else $error("failed flag cleared");

    // a retry count past any limit means the connection has failed
    a_count_implies_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        (link_reg.retries > 8'd15) |-> link_reg.failed)
        else $error("retry count beyond limit without failure");

    // the backed-off delay is zero unless a retransmit is requested
    a_delay_only_on_rexmit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_retransmit_now) |-> (m_next_timer_delay == '0))
        else $error("timer delay without retransmit");

    // a held request stays in its register until it moves on
    a_request_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_req_reg)
            && $stable(in_sample_reg)))
        else $error("request register lost a stalled request");

endmodule

/* dv/tb_rto_estimator_with_backoff.sv */
// tb_rto_estimator_with_backoff: self-checking bench for the rto estimator with backoff
// directed table then random events per config phase, scored against an in-bench predictor
// depends on rtoe_pkg and rto_estimator_with_backoff
module tb_rto_estimator_with_backoff;
    import rtoe_pkg::*;

    // one result as the block reports it
    typedef struct packed {
        logic [19:0] smoothed_rtt;
        logic [19:0] rtt_variance;
        logic [15:0] timeout_value;
        logic [30:0] next_timer_delay;
        logic        retransmit_now;
        logic        connection_failed;
        logic [16:0] congestion_window;
        logic [16:0] slow_start_threshold;
    } rto_result_t;

    // one row of the directed table
    typedef struct packed {
        req_type_t   kind;
        logic [19:0] sample;
        logic        has_want;
        rto_result_t want;
    } event_row_t;

    localparam rto_result_t NO_CHECK = '0;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [19:0] s_rtt_sample;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [19:0] m_smoothed_rtt;
    logic [19:0] m_rtt_variance;
    logic [15:0] m_timeout_value;
    logic [30:0] m_next_timer_delay;
    logic        m_retransmit_now;
    logic        m_connection_failed;
    logic [16:0] m_congestion_window;
    logic [16:0] m_slow_start_threshold;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // register shadow
    logic [9:0]  cfg_ticks;
    logic [3:0]  cfg_limit;
    logic [15:0] cfg_mss;
    logic [15:0] cfg_threshold;

    // estimator state as predicted
    logic [19:0] est_srtt;
    logic [19:0] est_rttvar;
    logic [15:0] est_rto;
    logic [16:0] est_cwnd;
    logic [16:0] est_ssthresh;
    logic [7:0]  est_retries;
    logic        est_failed;

    rto_result_t expected_results[$];
    event_row_t  directed_rows[$];
    int          mismatch_count = 0;
    int          source_idle_pct = 17;
    int          sink_idle_pct = 83;
    int          holds_asked = 0;
    int          holds_taken = 0;
    int          hold_left = 0;

    rto_estimator_with_backoff u_top (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_req_type             (s_req_type),
        .s_rtt_sample           (s_rtt_sample),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_smoothed_rtt         (m_smoothed_rtt),
        .m_rtt_variance         (m_rtt_variance),
        .m_timeout_value        (m_timeout_value),
        .m_next_timer_delay     (m_next_timer_delay),
        .m_retransmit_now       (m_retransmit_now),
        .m_connection_failed    (m_connection_failed),
        .m_congestion_window    (m_congestion_window),
        .m_slow_start_threshold (m_slow_start_threshold),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data)
    );

    always #10 aclk = ~aclk;

    // run limit
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // apply one event to the predicted state and return the result it reports
    function automatic rto_result_t estimate_event(input req_type_t kind,
                                                   input logic [19:0] sample);
        int          cur_s, cur_v, smp, delta, mag, tmp, lo, hi, ticks;
        logic [30:0] delay;
        logic        rexmit;
        logic        ok;
        logic [16:0] half, floor2;
        delay  = '0;
        rexmit = 1'b0;
        case (kind)
            REQ_RTT: begin
                if (est_srtt == 20'd0) begin
                    // unseeded: the sample seeds both estimates
                    est_srtt   = sample;
                    est_rttvar = sample >> 1;
                end else begin
                    // signed delta, floor division via arithmetic shift
                    cur_s = est_srtt;
                    cur_v = est_rttvar;
                    smp   = sample;
                    delta = smp - cur_s;
                    mag   = (delta < 0) ? -delta : delta;
                    tmp   = cur_s + (delta >>> 3);
                    est_srtt = tmp[19:0];
                    tmp   = mag - cur_v;
                    tmp   = cur_v + (tmp >>> 2);
                    est_rttvar = tmp[19:0];
                end
                cur_s = est_srtt;
                cur_v = est_rttvar;
                tmp   = cur_s + (cur_v << 2);
                ticks = cfg_ticks;
                lo    = ticks >> 1;
                hi    = ticks * 60;
                if (tmp < lo) tmp = lo;
                if (tmp > hi) tmp = hi;
                est_rto = tmp[15:0];
            end
            REQ_EXPIRY: begin
                ok = (est_retries < {4'd0, cfg_limit});
                if (est_retries != RETRY_MAX) est_retries = est_retries + 8'd1;
                if (ok) begin
                    rexmit = 1'b1;
                    delay  = {15'd0, est_rto} << est_retries[3:0];
                end else begin
                    est_failed = 1'b1;
                end
            end
            REQ_CONGEST: begin
                // halve the window, never below two segments
                half   = est_cwnd >> 1;
                floor2 = {cfg_mss, 1'b0};
                est_ssthresh = (half > floor2) ? half : floor2;
                est_cwnd     = est_ssthresh;
            end
            default: begin
            end
        endcase
        return {est_srtt, est_rttvar, est_rto, delay, rexmit, est_failed,
                est_cwnd, est_ssthresh};
    endfunction

    // offer one request, wait for acceptance, queue what it should produce
    task automatic send_event(input req_type_t kind, input logic [19:0] sample,
                              input logic has_want, input rto_result_t want);
        rto_result_t predicted;
        while ($urandom_range(99) < source_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= kind;
        s_rtt_sample <= sample;
        do @(posedge aclk); while (!s_ready);
        predicted = estimate_event(kind, sample);
        expected_results.push_back(has_want ? want : predicted);
        @(negedge aclk);
    endtask

    // config write; the caller lowers cfg_valid after its last write
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_TICKS:     cfg_ticks     = data[9:0];
            CFG_LIMIT:     cfg_limit     = data[3:0];
            CFG_MSS:       cfg_mss       = data;
            CFG_THRESHOLD: cfg_threshold = data;
            default: begin
            end
        endcase
        @(negedge aclk);
    endtask

    // rtt sample, shaped around the current estimate in three draws out of ten
    function automatic logic [19:0] pick_sample();
        int          c, span, off;
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(9))
            0: return 20'd0;
            1: return w[19:0];
            2: return {12'd0, w[7:0]};
            3, 4, 5: begin
                c    = est_srtt;
                span = c / 4 + 8;
                off  = $urandom_range(2 * span);
                c    = c + off - span;
                if (c < 0) c = 0;
                if (c > 1048575) c = 1048575;
                return c[19:0];
            end
            default: begin
                c = $urandom_range(5000, 50);
                return c[19:0];
            end
        endcase
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_taken != holds_asked) begin
            m_ready     <= 1'b0;
            hold_left   <= 63;
            holds_taken <= holds_taken + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic void check_field(input string name, input logic [30:0] want,
                                        input logic [30:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // score each result against the oldest expectation
    always @(posedge aclk) begin : score_results
        rto_result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding");
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("smoothed_rtt", want.smoothed_rtt, m_smoothed_rtt);
                check_field("rtt_variance", want.rtt_variance, m_rtt_variance);
                check_field("timeout_value", want.timeout_value, m_timeout_value);
                check_field("next_timer_delay", want.next_timer_delay, m_next_timer_delay);
                check_field("retransmit_now", want.retransmit_now, m_retransmit_now);
                check_field("connection_failed", want.connection_failed,
                            m_connection_failed);
                check_field("congestion_window", want.congestion_window,
                            m_congestion_window);
                check_field("slow_start_threshold", want.slow_start_threshold,
                            m_slow_start_threshold);
            end
        end
    end

    initial begin : stimulus
        int          p, k, r;
        req_type_t   kind;
        logic [19:0] sample;
        logic [31:0] w;
        logic [9:0]  tk;
        logic [3:0]  lim;
        logic [15:0] mss, thr;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = REQ_RTT;
        s_rtt_sample = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_TICKS;
        cfg_data     = '0;

        // predicted state after reset
        cfg_ticks     = RESET_TICKS;
        cfg_limit     = RESET_LIMIT;
        cfg_mss       = RESET_MSS;
        cfg_threshold = RESET_THRESHOLD;
        est_srtt      = '0;
        est_rttvar    = '0;
        est_rto       = {6'd0, RESET_TICKS};
        est_cwnd      = {1'b0, RESET_MSS};
        est_ssthresh  = {1'b0, RESET_THRESHOLD};
        est_retries   = '0;
        est_failed    = 1'b0;

        // directed table, default config
        // unused type reports the reset state untouched
        directed_rows.push_back({REQ_UNUSED, 20'hFFFFF, 1'b1,
            {20'd0, 20'd0, 16'd1000, 31'd0, 1'b0, 1'b0, 17'd1460, 17'd65535}});
        // zero sample while unseeded: rto lands on the lower bound
        directed_rows.push_back({REQ_RTT, 20'h00000, 1'b1,
            {20'd0, 20'd0, 16'd500, 31'd0, 1'b0, 1'b0, 17'd1460, 17'd65535}});
        // largest sample seeds, rto clamps to the upper bound
        directed_rows.push_back({REQ_RTT, 20'hFFFFF, 1'b1,
            {20'hFFFFF, 20'h7FFFF, 16'd60000, 31'd0, 1'b0, 1'b0, 17'd1460, 17'd65535}});
        // most negative delta, then a tiny sample
        directed_rows.push_back({REQ_RTT, 20'h00000, 1'b0, NO_CHECK});
        directed_rows.push_back({REQ_RTT, 20'h00001, 1'b0, NO_CHECK});
        directed_rows.push_back({REQ_EXPIRY, 20'h00000, 1'b0, NO_CHECK});
        // two congestion events, both landing on the two segment floor
        directed_rows.push_back({REQ_CONGEST, 20'hFFFFF, 1'b0, NO_CHECK});
        directed_rows.push_back({REQ_CONGEST, 20'h00000, 1'b0, NO_CHECK});
        directed_rows.push_back({REQ_EXPIRY, 20'h5A5A5, 1'b0, NO_CHECK});
        directed_rows.push_back({REQ_RTT, 20'h03039, 1'b0, NO_CHECK});
        // expiries up to the retry limit and one past it
        directed_rows.push_back({REQ_EXPIRY, 20'h00000, 1'b0, NO_CHECK});
        directed_rows.push_back({REQ_EXPIRY, 20'hFFFFF, 1'b0, NO_CHECK});
        directed_rows.push_back({REQ_EXPIRY, 20'h00000, 1'b0, NO_CHECK});
        directed_rows.push_back({REQ_EXPIRY, 20'h00000, 1'b0, NO_CHECK});
        // events after failure still update state
        directed_rows.push_back({REQ_RTT, 20'h0AAAA, 1'b0, NO_CHECK});
        directed_rows.push_back({REQ_UNUSED, 20'h55555, 1'b0, NO_CHECK});
        directed_rows.push_back({REQ_CONGEST, 20'h00000, 1'b0, NO_CHECK});
        directed_rows.push_back({REQ_EXPIRY, 20'h00000, 1'b0, NO_CHECK});
        directed_rows.push_back({REQ_RTT, 20'hFFFFF, 1'b0, NO_CHECK});

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_event(directed_rows[i].kind, directed_rows[i].sample,
                       directed_rows[i].has_want, directed_rows[i].want);

        // random phases, each with its own register setting
        for (p = 0; p < 6; p++) begin
            s_valid <= 1'b0;
            while (expected_results.size() != 0) @(negedge aclk);

            case (p)
                0: begin tk = 10'd1023; lim = 4'd15; mss = 16'hFFFF; thr = 16'd0;     end
                1: begin tk = 10'd0;    lim = 4'd0;  mss = 16'd0;    thr = 16'hFFFF;  end
                2: begin tk = 10'd100;  lim = 4'd7;  mss = 16'd1;    thr = 16'd1;     end
                3: begin tk = 10'd1;    lim = 4'd3;  mss = 16'd536;  thr = 16'h8000;  end
                4: begin
                    w   = $urandom();
                    tk  = w[9:0];
                    lim = w[13:10];
                    w   = $urandom();
                    mss = w[15:0];
                    thr = w[31:16];
                end
                default: begin
                    tk = RESET_TICKS; lim = RESET_LIMIT; mss = RESET_MSS;
                    thr = RESET_THRESHOLD;
                end
            endcase
            // spare upper bits of the narrow registers carry junk
            w = $urandom();
            write_reg(CFG_TICKS, {w[5:0], tk});
            write_reg(CFG_LIMIT, {w[17:6], lim});
            write_reg(CFG_MSS, mss);
            write_reg(CFG_THRESHOLD, thr);
            cfg_valid <= 1'b0;

            case (p)
                0, 1: begin source_idle_pct = 17; sink_idle_pct = 83; end
                2, 3: begin source_idle_pct = 83; sink_idle_pct = 17; end
                default: begin source_idle_pct = 0; sink_idle_pct = 0; end
            endcase

            for (k = 0; k < 290; k++) begin
                // long receiver hold-off while requests keep coming
                if (p == 4 && k == 100) holds_asked = holds_asked + 1;
                r = $urandom_range(99);
                kind = (r < 45) ? REQ_RTT : (r < 70) ? REQ_EXPIRY :
                       (r < 93) ? REQ_CONGEST : REQ_UNUSED;
                if (kind == REQ_RTT) begin
                    sample = pick_sample();
                end else begin
                    w = $urandom();
                    sample = w[19:0];
                end
                send_event(kind, sample, 1'b0, NO_CHECK);
            end
        end

        // drain the outstanding results, then wait before the final check
        s_valid <= 1'b0;
        for (k = 0; k < 5000 && expected_results.size() != 0; k++) @(negedge aclk);
        repeat (4) @(negedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
